FILE: hw/rtl/alm_pkg.sv
`timescale 1ns / 1ps

package alm_pkg;

    localparam int SAMPLE_W    = 24;
    localparam int MAG_W       = 24;
    localparam int TERM_W      = 47;
    localparam int ACC_W       = 64;
    localparam int COUNT_W     = 17;
    localparam int LEVEL_W     = 47;
    localparam int MODE_W      = 2;
    localparam int MAX_SAMPLES = 65536;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int DIV_STEPS   = ACC_W;
    localparam int STEP_W      = $clog2(DIV_STEPS);

    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    localparam logic [MODE_W-1:0] MODE_MEAN   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SQUARE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PEAK   = 2'd2;

    localparam logic OPC_ACCUMULATE = 1'b0;
    localparam logic OPC_READOUT    = 1'b1;

    typedef enum logic [1:0] {
        OP_ACC_MAG = 2'd0,
        OP_ACC_SQ  = 2'd1,
        OP_PEAK    = 2'd2,
        OP_READ    = 2'd3
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [MAG_W-1:0] mag;
    } t_queue_entry;

    typedef struct packed {
        logic [ACC_W-1:0]   dividend;
        logic [COUNT_W-1:0] divisor;
        logic               flag;
    } t_div_req;

endpackage

FILE: hw/rtl/alm_if.sv
`timescale 1ns / 1ps

interface alm_in_if;
    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic signed [alm_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output opcode, output sample, input ready);
    modport sink (input valid, input opcode, input sample, output ready);
endinterface

interface alm_out_if;
    logic                         valid;
    logic                         ready;
    logic [alm_pkg::LEVEL_W-1:0]  level;
    logic [alm_pkg::COUNT_W-1:0]  sample_count;
    logic                         saturated;

    modport source (output valid, output level, output sample_count, output saturated,
                    input ready);
    modport sink (input valid, input level, input sample_count, input saturated,
                  output ready);
endinterface

FILE: hw/rtl/audio_level_meter_top.sv
`timescale 1ns / 1ps

// Audio level meter. Each accumulate item adds one signed 24-bit sample's magnitude, its square
// or its running peak, as the mode register selects, and is taken at one item per clock cycle
// while the four-entry queue between the front and back parts has room. A readout item hands
// the accumulator and the sample count to a restoring divider that produces one quotient bit
// per cycle while it runs and holds its result in the output register; samples that follow it
// keep being accumulated meanwhile, and a second readout waits until the first result has been
// taken from the output register. Samples that arrive in the unused mode 3 are accepted and
// ignored. The mode register lies at byte address 0 and should be written only while idle.

module audio_level_meter_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    alm_in_if.sink                            i_in,
    alm_out_if.source                         o_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [alm_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [alm_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [alm_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    logic [alm_pkg::MODE_W-1:0] r_mode;
    logic                       push;
    alm_pkg::t_queue_entry      push_entry;
    logic                       q_full;
    logic                       q_valid;
    alm_pkg::t_queue_entry      q_entry;
    logic                       q_pop;
    logic                       req_valid;
    alm_pkg::t_div_req          req;
    logic                       req_ready;
    logic                       reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[alm_pkg::APB_ADDR_W-1] == 1'b0);
    assign prdata  = reg_sel ? alm_pkg::APB_DATA_W'(r_mode) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= alm_pkg::MODE_MEAN;
        end else if (psel && penable && pwrite && reg_sel) begin
            r_mode <= pwdata[alm_pkg::MODE_W-1:0];
        end
    end

    alm_front u_front (
        .i_in         (i_in),
        .i_mode       (r_mode),
        .i_queue_full (q_full),
        .o_push       (push),
        .o_entry      (push_entry)
    );

    alm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    alm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_entry   (q_entry),
        .o_q_pop     (q_pop),
        .o_req_valid (req_valid),
        .o_req       (req),
        .i_req_ready (req_ready)
    );

    alm_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_valid),
        .i_req       (req),
        .o_req_ready (req_ready),
        .o_out       (o_out)
    );

endmodule

FILE: hw/rtl/alm_front.sv
`timescale 1ns / 1ps

module alm_front (
    alm_in_if.sink                    i_in,
    input  logic [alm_pkg::MODE_W-1:0] i_mode,
    input  logic                      i_queue_full,
    output logic                      o_push,
    output alm_pkg::t_queue_entry     o_entry
);

    logic [alm_pkg::MAG_W-1:0] mag;
    logic                      keep;

    always_comb begin
        mag = i_in.sample[alm_pkg::SAMPLE_W-1] ? (~i_in.sample + 1'b1) : i_in.sample;
    end

    always_comb begin
        keep      = 1'b1;
        o_entry.mag = mag;
        o_entry.op  = alm_pkg::OP_READ;
        if (i_in.opcode == alm_pkg::OPC_ACCUMULATE) begin
            unique case (i_mode)
                alm_pkg::MODE_MEAN:   o_entry.op = alm_pkg::OP_ACC_MAG;
                alm_pkg::MODE_SQUARE: o_entry.op = alm_pkg::OP_ACC_SQ;
                alm_pkg::MODE_PEAK:   o_entry.op = alm_pkg::OP_PEAK;
                default:              keep = 1'b0;
            endcase
        end
    end

    assign i_in.ready = !i_queue_full;
    assign o_push     = i_in.valid && !i_queue_full && keep;

endmodule

FILE: hw/rtl/alm_queue.sv
`timescale 1ns / 1ps

module alm_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  alm_pkg::t_queue_entry i_entry,
    input  logic                  i_pop,
    output logic                  o_full,
    output logic                  o_valid,
    output alm_pkg::t_queue_entry o_entry
);

    alm_pkg::t_queue_entry             r_mem [alm_pkg::QUEUE_DEPTH];
    logic [alm_pkg::QPTR_W-1:0]        r_wr_ptr;
    logic [alm_pkg::QPTR_W-1:0]        r_rd_ptr;
    logic [alm_pkg::QCNT_W-1:0]        r_count;
    logic [alm_pkg::QCNT_W-1:0]        n_count;
    logic                              do_push;
    logic                              do_pop;

    assign o_full  = (r_count == alm_pkg::QCNT_W'(alm_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

FILE: hw/rtl/alm_back.sv
`timescale 1ns / 1ps

module alm_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  alm_pkg::t_queue_entry i_q_entry,
    output logic                  o_q_pop,
    output logic                  o_req_valid,
    output alm_pkg::t_div_req     o_req,
    input  logic                  i_req_ready
);

    logic                          r_t_valid;
    alm_pkg::t_op                  r_t_op;
    logic [alm_pkg::TERM_W-1:0]    r_t_term;
    logic [alm_pkg::ACC_W-1:0]     r_acc;
    logic [alm_pkg::COUNT_W-1:0]   r_count;
    logic                          r_flag;
    logic [alm_pkg::ACC_W-1:0]     n_acc;
    logic [alm_pkg::COUNT_W-1:0]   n_count;
    logic                          n_flag;
    logic                          t_adv;
    logic [2*alm_pkg::MAG_W-1:0]   square;
    logic [alm_pkg::ACC_W:0]       sum;

    assign t_adv   = r_t_valid && ((r_t_op != alm_pkg::OP_READ) || i_req_ready);
    assign o_q_pop = i_q_valid && (!r_t_valid || t_adv);

    assign o_req_valid    = r_t_valid && (r_t_op == alm_pkg::OP_READ);
    assign o_req.dividend = r_acc;
    assign o_req.divisor  = r_count;
    assign o_req.flag     = r_flag;

    assign square = i_q_entry.mag * i_q_entry.mag;
    assign sum    = {1'b0, r_acc} + (alm_pkg::ACC_W + 1)'(r_t_term);

    always_comb begin
        n_acc   = r_acc;
        n_count = r_count;
        n_flag  = r_flag;
        if (t_adv) begin
            unique case (r_t_op)
                alm_pkg::OP_ACC_MAG, alm_pkg::OP_ACC_SQ: begin
                    if (r_count >= alm_pkg::COUNT_W'(alm_pkg::MAX_SAMPLES)) begin
                        n_flag = 1'b1;
                    end else begin
                        n_acc   = sum[alm_pkg::ACC_W] ? '1 : sum[alm_pkg::ACC_W-1:0];
                        n_count = r_count + 1'b1;
                    end
                end
                alm_pkg::OP_PEAK: begin
                    if (alm_pkg::ACC_W'(r_t_term) > r_acc) begin
                        n_acc = alm_pkg::ACC_W'(r_t_term);
                    end
                    n_count = alm_pkg::COUNT_W'(1);
                end
                alm_pkg::OP_READ: begin
                    n_acc   = '0;
                    n_count = '0;
                    n_flag  = 1'b0;
                end
                default: begin
                    n_acc = r_acc;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_valid <= 1'b0;
            r_acc     <= '0;
            r_count   <= '0;
            r_flag    <= 1'b0;
        end else begin
            r_acc   <= n_acc;
            r_count <= n_count;
            r_flag  <= n_flag;
            if (o_q_pop) begin
                r_t_valid <= 1'b1;
            end else if (t_adv) begin
                r_t_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_t_op <= i_q_entry.op;
            if (i_q_entry.op == alm_pkg::OP_ACC_SQ) begin
                r_t_term <= square[alm_pkg::TERM_W-1:0];
            end else begin
                r_t_term <= alm_pkg::TERM_W'(i_q_entry.mag);
            end
        end
    end

endmodule

FILE: hw/rtl/alm_div.sv
`timescale 1ns / 1ps

module alm_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  alm_pkg::t_div_req i_req,
    output logic              o_req_ready,
    alm_out_if.source         o_out
);

    typedef enum logic [2:0] {
        DIV_IDLE = 3'b001,
        DIV_RUN  = 3'b010,
        DIV_DONE = 3'b100
    } t_div_state;

    t_div_state                    r_state;
    t_div_state                    n_state;
    logic [alm_pkg::STEP_W-1:0]    r_step;
    logic [alm_pkg::ACC_W-1:0]     r_quot;
    logic [alm_pkg::COUNT_W-1:0]   r_rem;
    logic [alm_pkg::COUNT_W-1:0]   r_div;
    logic                          r_flag;
    logic [alm_pkg::LEVEL_W-1:0]   r_level;
    logic [alm_pkg::COUNT_W:0]     partial;
    logic [alm_pkg::COUNT_W:0]     diff;
    logic                          ge;
    logic [alm_pkg::ACC_W-1:0]     n_quot;
    logic [alm_pkg::COUNT_W-1:0]   n_rem;
    logic                          last;

    assign o_req_ready        = (r_state == DIV_IDLE);
    assign o_out.valid        = (r_state == DIV_DONE);
    assign o_out.level        = r_level;
    assign o_out.sample_count = r_div;
    assign o_out.saturated    = r_flag;

    assign partial = {r_rem, r_quot[alm_pkg::ACC_W-1]};
    assign diff    = partial - {1'b0, r_div};
    assign ge      = (partial >= {1'b0, r_div});
    assign n_rem   = ge ? diff[alm_pkg::COUNT_W-1:0] : partial[alm_pkg::COUNT_W-1:0];
    assign n_quot  = {r_quot[alm_pkg::ACC_W-2:0], ge};
    assign last    = (r_step == alm_pkg::STEP_W'(alm_pkg::DIV_STEPS - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            DIV_IDLE: begin
                if (i_req_valid) begin
                    n_state = DIV_RUN;
                end
            end
            DIV_RUN: begin
                if (last) begin
                    n_state = DIV_DONE;
                end
            end
            DIV_DONE: begin
                if (o_out.ready) begin
                    n_state = DIV_IDLE;
                end
            end
            default: n_state = DIV_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DIV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == DIV_IDLE && i_req_valid) begin
            r_quot <= i_req.dividend;
            r_div  <= i_req.divisor;
            r_flag <= i_req.flag;
            r_rem  <= '0;
            r_step <= '0;
        end else if (r_state == DIV_RUN) begin
            r_quot <= n_quot;
            r_rem  <= n_rem;
            r_step <= r_step + 1'b1;
            if (last) begin
                if (r_div == '0) begin
                    r_level <= '0;
                end else if (n_quot[alm_pkg::ACC_W-1:alm_pkg::LEVEL_W] != '0) begin
                    r_level <= '1;
                end else begin
                    r_level <= n_quot[alm_pkg::LEVEL_W-1:0];
                end
            end
        end
    end

endmodule
